@@ sv/tpm_pkg.sv @@
// ----------------------------------------------------------------------------
// Ternary priority match table package
// Shared sizes, request codes and the request, entry and result types.
// ----------------------------------------------------------------------------
package tpm_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int KEY_BITS      = 64;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam int FIELD_KEY_W  = 64;
  localparam int PRI_W        = 16;
  localparam int HANDLE_W     = 8;
  localparam int REQ_W        = 3;

  localparam logic [REQ_W-1:0] REQ_LOOKUP = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ADD    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_EXISTS = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0]       req_type;
    logic [FIELD_KEY_W-1:0] search_key;
    logic [FIELD_KEY_W-1:0] key_mask;
    logic [PRI_W-1:0]       entry_priority;
    logic [HANDLE_W-1:0]    entry_handle;
  } req_t;

  typedef struct packed {
    logic [PRI_W-1:0]    priority_num;
    logic [KEY_BITS-1:0] mask;
    logic [KEY_BITS-1:0] value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] match_handle;
    logic                status;
  } res_t;

endpackage

@@ sv/tpm_ram.sv @@
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/tpm_ctrl.sv @@
// ----------------------------------------------------------------------------
// Ternary priority match table sequencer
// Holds the valid bits, writes entries and scans the entry RAM one slot per
// cycle for lookup, delete and exists requests.
// ----------------------------------------------------------------------------
module tpm_ctrl
  import tpm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic idle,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_HOLD  = 2'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic [1:0]              state;
  logic [TABLE_ENTRIES-1:0] valid;
  logic [IDX_W-1:0]        cnt;
  logic [REQ_W-1:0]        op;
  logic [KEY_BITS-1:0]     key;
  logic [KEY_BITS-1:0]     mask;
  logic [PRI_W-1:0]        pri;

  // Compare stage, registered behind the read address.
  logic                    v1;
  logic                    vbit1;
  logic [IDX_W-1:0]        idx1;
  entry_t                  entry;
  logic [ENTRY_W-1:0]      rd_data;

  logic                    found;
  logic [IDX_W-1:0]        best;
  logic [PRI_W-1:0]        best_pri;

  logic                    add_in_range;
  logic                    wr_en;
  entry_t                  wr_entry;
  logic                    take;

  assign add_in_range = 32'(req.entry_handle) < 32'(TABLE_ENTRIES);
  assign wr_en = (state == S_IDLE) && start && (req.req_type == REQ_ADD) && add_in_range;
  assign wr_entry.priority_num = req.entry_priority;
  assign wr_entry.mask         = KEY_BITS'(req.key_mask);
  assign wr_entry.value        = KEY_BITS'(req.search_key);

  tpm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(IDX_W'(req.entry_handle)),
    .wr_data(wr_entry),
    .rd_en  (state == S_SCAN),
    .rd_addr(cnt),
    .rd_data(rd_data)
  );

  assign entry = entry_t'(rd_data);

  // Lookup keeps the strictly smaller priority, so ties go to the lower slot.
  always_comb begin
    if (op == REQ_LOOKUP) begin
      take = ((key & entry.mask) == entry.value) &&
             (!found || (entry.priority_num < best_pri));
    end else begin
      take = (entry.value == key) && (entry.mask == mask) &&
             (entry.priority_num == pri) && !found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      found <= 1'b0;
      v1    <= 1'b0;
    end else begin
      v1 <= (state == S_SCAN);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            found <= 1'b0;
            cnt   <= '0;
            unique case (req.req_type)
              REQ_ADD: begin
                if (add_in_range) begin
                  valid[IDX_W'(req.entry_handle)] <= 1'b1;
                end
                state <= S_HOLD;
              end
              REQ_CLEAR: begin
                valid <= '0;
                state <= S_HOLD;
              end
              REQ_LOOKUP, REQ_DELETE, REQ_EXISTS: begin
                state <= S_SCAN;
              end
              default: begin
                state <= S_HOLD;
              end
            endcase
          end
        end
        S_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_IDX) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_HOLD;
        end
        S_HOLD: begin
          if (res_ready) begin
            if ((op == REQ_DELETE) && found) begin
              valid[best] <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (v1 && vbit1 && take) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && start) begin
      op   <= req.req_type;
      key  <= KEY_BITS'(req.search_key);
      mask <= KEY_BITS'(req.key_mask);
      pri  <= req.entry_priority;
    end
    if (state == S_SCAN) begin
      idx1  <= cnt;
      vbit1 <= valid[cnt];
    end
    if (v1 && vbit1 && take) begin
      best     <= idx1;
      best_pri <= entry.priority_num;
    end
  end

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_HOLD);

  always_comb begin
    res.hit          = found;
    res.match_handle = ((op == REQ_LOOKUP) && found) ? HANDLE_W'(best) : '0;
    res.status       = (op == REQ_DELETE) && !found;
  end

endmodule

@@ sv/ternary_priority_match_table.sv @@
// ----------------------------------------------------------------------------
// Ternary priority match table
// Table of value/mask/priority entries addressed by handle, with lookup,
// add, delete, exists and clear requests.
// ----------------------------------------------------------------------------
// Usage: a request enters on the s_ stream (s_tuser carries the request
// type) and exactly one result leaves on the m_ stream for every request.
// Requests are served one at a time, in order. Add, clear and unknown codes
// go straight from idle to the hold state, where the result waits for the
// output register, and the next request is taken once the sequencer is
// back in idle. Lookup, delete and exists read the entry RAM one slot per
// cycle, then pass through a drain state for the last compare before the
// hold state; the single RAM read port limits the scan, and the next
// request again waits for the return to idle.
// The result sits in an output register, so a new request is taken while
// an earlier result still waits; if the receiver stalls, the finished
// result of the next request holds inside the sequencer and s_tready stays
// low until the output register frees. Reset invalidates every entry at once
// through the per-slot valid flops; the entry RAM itself needs no clearing.
// ----------------------------------------------------------------------------
module ternary_priority_match_table
  import tpm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // search_key [63:0], key_mask [127:64], entry_priority [143:128],
  // entry_handle [151:144]
  input  logic [151:0] s_tdata,
  // req_type [2:0]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit [0], match_handle [8:1], status [9], zero [15:10]
  output logic [15:0]  m_tdata
);

  req_t req;
  logic start;
  logic idle;
  logic res_valid;
  logic res_ready;
  res_t res;
  res_t out_res;

  assign req.req_type       = s_tuser;
  assign req.search_key     = s_tdata[63:0];
  assign req.key_mask       = s_tdata[127:64];
  assign req.entry_priority = s_tdata[143:128];
  assign req.entry_handle   = s_tdata[151:144];

  assign s_tready  = idle;
  assign start     = s_tvalid && idle;
  assign res_ready = !m_tvalid || m_tready;

  tpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req),
    .idle     (idle),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {6'd0, out_res.status, out_res.match_handle, out_res.hit};

endmodule

@@ tb/sv/ternary_priority_match_table_test.sv @@
// ----------------------------------------------------------------------------
// Ternary priority match table testbench
// Drives lookup, add, delete, exists, clear and spare request codes into the
// table. It keeps its own copy of the table, works out the answer for each
// accepted request, and checks every result transfer against that answer.
// Both stream sides idle at random, except in a final calm stretch.
// ----------------------------------------------------------------------------
module ternary_priority_match_table_test;
  import tpm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [REQ_W-1:0] REQ_SPARE_LO = REQ_W'(REQ_CLEAR + 1);
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = '1;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [151:0] s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [15:0]  m_tdata;

  ternary_priority_match_table DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Shadow copy of the table.
  logic [KEY_BITS-1:0] ent_value [TABLE_ENTRIES];
  logic [KEY_BITS-1:0] ent_mask  [TABLE_ENTRIES];
  logic [PRI_W-1:0]    ent_pri   [TABLE_ENTRIES];
  bit                  ent_live  [TABLE_ENTRIES];

  res_t answers_due[$];
  int   errors = 0;
  bit   calm = 1'b0;
  int unsigned cycle_count = 0;

  int n_lookup = 0, n_lookup_hit = 0, n_add = 0, n_delete = 0, n_delete_hit = 0;
  int n_exists = 0, n_clear = 0, n_spare = 0;

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      ent_live[i] = 1'b0;
    end
  end

  function automatic int locate_slot(input logic [KEY_BITS-1:0] val,
                                     input logic [KEY_BITS-1:0] msk,
                                     input logic [PRI_W-1:0] pri);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (ent_live[i] && ent_value[i] == val && ent_mask[i] == msk && ent_pri[i] == pri)
        return i;
    end
    return -1;
  endfunction

  // Applies one request to the shadow table and returns the result it must give.
  function automatic res_t table_answer(input logic [REQ_W-1:0] kind,
                                        input logic [KEY_BITS-1:0] key,
                                        input logic [KEY_BITS-1:0] msk,
                                        input logic [PRI_W-1:0] pri,
                                        input logic [HANDLE_W-1:0] handle);
    res_t r;
    int   best;
    logic [PRI_W-1:0] best_pri;
    r = '0;
    best = -1;
    best_pri = '0;
    case (kind)
      REQ_LOOKUP: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (ent_live[i] && (best < 0 || ent_pri[i] < best_pri) &&
              (key & ent_mask[i]) == ent_value[i]) begin
            best = i;
            best_pri = ent_pri[i];
          end
        end
        if (best >= 0) begin
          r.hit = 1'b1;
          r.match_handle = HANDLE_W'(best);
        end
      end
      REQ_ADD: begin
        if (handle < TABLE_ENTRIES) begin
          ent_value[handle] = key;
          ent_mask[handle]  = msk;
          ent_pri[handle]   = pri;
          ent_live[handle]  = 1'b1;
        end
      end
      REQ_DELETE: begin
        best = locate_slot(key, msk, pri);
        if (best >= 0) begin
          ent_live[best] = 1'b0;
          r.hit = 1'b1;
        end else begin
          r.status = 1'b1;
        end
      end
      REQ_EXISTS: begin
        r.hit = (locate_slot(key, msk, pri) >= 0);
      end
      REQ_CLEAR: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          ent_live[i] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic logic [KEY_BITS-1:0] rand_key();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[KEY_BITS-1:0];
  endfunction

  function automatic logic [KEY_BITS-1:0] pick_mask();
    logic [KEY_BITS-1:0] m;
    case ($urandom_range(0, 5))
      0: m = '1;
      1: m = '0;
      2: m = rand_key() & rand_key();
      3: begin
        m = '1;
        m = m << $urandom_range(0, KEY_BITS);
      end
      default: m = rand_key();
    endcase
    return m;
  endfunction

  // Small priorities dominate so that ties between matching entries are common.
  function automatic logic [PRI_W-1:0] pick_priority();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return PRI_W'($urandom());
      default: return PRI_W'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic int pick_live_slot();
    int live[$];
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (ent_live[i]) live.push_back(i);
    end
    if (live.size() == 0) return -1;
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  // Sends one request and records its expected result once the transfer happens.
  task automatic send_req(input logic [REQ_W-1:0] kind,
                          input logic [KEY_BITS-1:0] key,
                          input logic [KEY_BITS-1:0] msk,
                          input logic [PRI_W-1:0] pri,
                          input logic [HANDLE_W-1:0] handle);
    int   gap;
    res_t want;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {handle, pri, msk, key};
    do @(posedge clk); while (s_tready !== 1'b1);
    want = table_answer(kind, key, msk, pri, handle);
    answers_due.push_back(want);
    case (kind)
      REQ_LOOKUP: begin
        n_lookup++;
        if (want.hit) n_lookup_hit++;
      end
      REQ_ADD:    n_add++;
      REQ_DELETE: begin
        n_delete++;
        if (want.hit) n_delete_hit++;
      end
      REQ_EXISTS: n_exists++;
      REQ_CLEAR:  n_clear++;
      default:    n_spare++;
    endcase
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stall bursts, none once the run has gone calm.
  initial begin
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 14)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    res_t got, want;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      // Result layout: hit at bit 0, match_handle at bits 8:1, status at bit 9.
      got = '0;
      got.hit = m_tdata[0];
      got.match_handle = m_tdata[8:1];
      got.status = m_tdata[9];
      if (answers_due.size() == 0) begin
        $error("result transfer with no request outstanding: %h", m_tdata);
        errors++;
      end else begin
        want = answers_due.pop_front();
        if (got.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, got.hit);
          errors++;
        end
        if (got.match_handle !== want.match_handle) begin
          $error("match_handle: expected %0d, got %0d", want.match_handle, got.match_handle);
          errors++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, answers_due.size());
      $display("ternary_priority_match_table_test: done, errors");
      $finish;
    end
  end

  task automatic test_empty_table();
    send_req(REQ_LOOKUP, rand_key(), rand_key(), pick_priority(), '0);
    send_req(REQ_DELETE, rand_key(), rand_key(), pick_priority(), '1);
    send_req(REQ_EXISTS, rand_key(), rand_key(), pick_priority(), '0);
    send_req(REQ_CLEAR, '0, '0, '0, '0);
  endtask

  task automatic test_priority_and_ties();
    send_req(REQ_ADD, '0, '0, '1, 8'd0);           // wildcard, worst priority
    send_req(REQ_ADD, '1, '1, '0, 8'd255);         // exact all-ones, best priority
    send_req(REQ_LOOKUP, '1, '0, '0, '0);
    send_req(REQ_LOOKUP, '0, '0, '0, '0);
    // A value bit outside its mask means the entry can never match.
    send_req(REQ_ADD, 64'h1, '0, '0, 8'd10);
    send_req(REQ_LOOKUP, 64'h1, '0, '0, '0);
    send_req(REQ_ADD, 64'h1200, 64'hFF00, 16'd5, 8'd20);
    send_req(REQ_ADD, 64'h1200, 64'hFF00, 16'd5, 8'd30);
    send_req(REQ_LOOKUP, 64'h12AB, '0, '0, '0);
    // Overwriting handle 20 with a worse priority hands the win to handle 30.
    send_req(REQ_ADD, 64'h1200, 64'hFF00, 16'd9, 8'd20);
    send_req(REQ_LOOKUP, 64'h12CD, '0, '0, '0);
  endtask

  task automatic test_delete_and_exists();
    send_req(REQ_ADD, 64'h1200, 64'hFF00, 16'd5, 8'd40);
    send_req(REQ_EXISTS, 64'h1200, 64'hFF00, 16'd5, '0);
    send_req(REQ_DELETE, 64'h1200, 64'hFF00, 16'd5, '0);
    send_req(REQ_EXISTS, 64'h1200, 64'hFF00, 16'd5, '0);
    send_req(REQ_LOOKUP, 64'h1234, '0, '0, '0);
    send_req(REQ_DELETE, 64'h1200, 64'hFF00, 16'd6, '0);
    send_req(REQ_DELETE, 64'h1200, 64'hFF00, 16'd5, '0);
    send_req(REQ_EXISTS, 64'h1200, 64'hFF00, 16'd5, '0);
  endtask

  task automatic test_spare_codes_and_clear();
    for (int c = REQ_SPARE_LO; c <= REQ_SPARE_HI; c++) begin
      send_req(REQ_W'(c), rand_key(), rand_key(), pick_priority(), HANDLE_W'($urandom()));
    end
    send_req(REQ_CLEAR, rand_key(), rand_key(), pick_priority(), HANDLE_W'($urandom()));
    send_req(REQ_LOOKUP, '1, '0, '0, '0);
    send_req(REQ_EXISTS, '1, '1, '0, '0);
  endtask

  // Mostly well-formed traffic: lookups aimed at live entries, deletes and
  // exists probes that copy live entries, plus near misses and plain noise.
  task automatic test_random_traffic(input int count, input int handle_span);
    int sent, roll, h;
    logic [REQ_W-1:0]    kind;
    logic [KEY_BITS-1:0] key, msk;
    logic [PRI_W-1:0]    pri;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(0, 199);
      h    = pick_live_slot();
      key  = rand_key();
      msk  = pick_mask();
      pri  = pick_priority();
      if (roll < 2) begin
        send_req(REQ_CLEAR, key, msk, pri, HANDLE_W'($urandom()));
        sent++;
      end else if (roll < 8) begin
        send_req(REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)), key, msk, pri,
                 HANDLE_W'($urandom()));
      end else if (roll < 70) begin
        if ($urandom_range(0, 7) != 0) key = key & msk;
        if (h >= 0 && $urandom_range(0, 5) == 0) begin
          key = ent_value[h];
          msk = ent_mask[h];
          pri = ent_pri[h];
        end
        send_req(REQ_ADD, key, msk, pri, HANDLE_W'($urandom_range(0, handle_span)));
        sent++;
      end else if (roll < 140) begin
        if (h >= 0 && $urandom_range(0, 3) != 0) key = ent_value[h] | (key & ~ent_mask[h]);
        send_req(REQ_LOOKUP, key, msk, pri, HANDLE_W'($urandom()));
        sent++;
      end else begin
        kind = (roll < 170) ? REQ_DELETE : REQ_EXISTS;
        if (h >= 0 && $urandom_range(0, 4) < 4) begin
          key = ent_value[h];
          msk = ent_mask[h];
          pri = ent_pri[h];
          if ($urandom_range(0, 3) == 0) pri = pri + 1'b1;
        end
        send_req(kind, key, msk, pri, HANDLE_W'($urandom()));
        sent++;
      end
    end
  endtask

  task automatic test_pause_until_drained();
    wait_drained();
    for (int i = 0; i < 40; i++) begin
      send_req(REQ_ADD, rand_key() & 64'hFFFF_0000, 64'hFFFF_0000, pick_priority(),
               HANDLE_W'($urandom()));
    end
    wait_drained();
    for (int i = 0; i < 10; i++) begin
      send_req(REQ_LOOKUP, rand_key(), '0, '0, '0);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_priority_and_ties();
    test_delete_and_exists();
    test_spare_codes_and_clear();
    test_random_traffic(500, 31);
    test_pause_until_drained();
    test_random_traffic(550, TABLE_ENTRIES - 1);
    calm = 1'b1;
    test_random_traffic(150, TABLE_ENTRIES - 1);
    wait_drained();
    repeat (TABLE_ENTRIES + 16) @(posedge clk);
    $display("requests: %0d lookups (%0d hits), %0d adds, %0d deletes (%0d hits),",
             n_lookup, n_lookup_hit, n_add, n_delete, n_delete_hit);
    $display("  %0d exists probes, %0d clears, %0d spare codes, in %0d cycles",
             n_exists, n_clear, n_spare, cycle_count);
    if (errors == 0) begin
      $display("ternary_priority_match_table_test: done, clean");
    end else begin
      $display("ternary_priority_match_table_test: done, errors");
    end
    $finish;
  end

endmodule
